>>> hw/rtl/trich_pkg.sv
// Shared constants, a lookup table and a helper function for the triangle channel.
`default_nettype none

package trich_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned AMP_W    = 4;
  localparam int unsigned NS_W     = 18;
  localparam int unsigned ACCUM_W  = 16;
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned QUOT_W   = 8;
  localparam int unsigned LIN_W    = 7;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned SEQ_STEPS = 32;
  localparam int unsigned STEP_W   = $clog2(SEQ_STEPS);
  localparam int unsigned ADV_SHIFT = 10;
  localparam int unsigned ADV_W    = NS_W - ADV_SHIFT;

  localparam logic [NS_W-1:0] NS_RESET = NS_W'(22675);

  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LINEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LENGTH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd3;

  localparam logic [IDX_W-1:0] REG_CONTROL = 2'd0;
  localparam logic [IDX_W-1:0] REG_PER_LO  = 2'd1;
  localparam logic [IDX_W-1:0] REG_PER_HI  = 2'd2;
  localparam logic [IDX_W-1:0] REG_LEN_EN  = 2'd3;

  localparam logic [LEN_W-1:0] LEN_TAB [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  // The first half of the sequence falls from 15 to 0, the second half rises back.
  function automatic logic [AMP_W-1:0] wave_level(input logic [STEP_W-1:0] idx);
    logic [STEP_W-2:0] low;
    low = idx[STEP_W-2:0];
    if (idx[STEP_W-1]) begin
      wave_level = AMP_W'(low);
    end else begin
      wave_level = AMP_W'(~low);
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trich_divider.sv
// Iterative restoring divider, one quotient bit per cycle, for the timer update.
`default_nettype none

module trich_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [trich_pkg::ACCUM_W-1:0]      dividend_i,
  input  logic [trich_pkg::PERIOD_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [trich_pkg::QUOT_W-1:0]       quot_o,
  output logic [trich_pkg::PERIOD_W-1:0]     rem_o
);
  import trich_pkg::*;

  localparam int unsigned CNT_W = $clog2(ACCUM_W);

  logic [ACCUM_W-1:0]  dvd_q;
  logic [PERIOD_W-1:0] dvs_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [QUOT_W-1:0]   quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  assign trial = {rem_q, dvd_q[ACCUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ACCUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ACCUM_W-2:0], 1'b0};
      quo_q <= {quo_q[QUOT_W-2:0], ge};
      if (ge) begin
        rem_q <= diff[PERIOD_W-1:0];
      end else begin
        rem_q <= trial[PERIOD_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/triangle_wave_channel.sv
// Top level of the triangle wave channel: registers, counters, sequencer and output stage.
`default_nettype none

// Register writes and counter ticks complete in the cycle of their transfer and return
// nothing. A sample request returns one amplitude. In the cycle of its transfer it adds
// the timer advance to the accumulator; the input is then stalled while the channel starts
// the divider, runs the 16 iterations of the bit-serial restoring divider that computes
// how many timer periods have elapsed (one iteration per accumulator bit), collects its
// result, and steps the sequence and loads the output register. With a zero period or a
// zero accumulator the divider is skipped. The last step repeats for as long as the
// previous amplitude is still stalled at the output. The output register lets a new item
// enter while the previous amplitude still waits to be taken.
module triangle_wave_channel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [trich_pkg::NS_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [trich_pkg::REQ_W-1:0]     req_type_i,
  input  logic [trich_pkg::IDX_W-1:0]     reg_index_i,
  input  logic [trich_pkg::DATA_W-1:0]    write_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [trich_pkg::AMP_W-1:0]     amplitude_o
);
  import trich_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]          state_q;
  logic [NS_W-1:0]     ns_q;
  logic                ctrl_q;
  logic [LIN_W-1:0]    lin_load_q;
  logic [PERIOD_W-1:0] period_q;
  logic                len_en_q;
  logic [LEN_W-1:0]    len_cnt_q;
  logic                reload_q;
  logic [LIN_W-1:0]    lin_cnt_q;
  logic [ACCUM_W-1:0]  accum_q;
  logic [STEP_W-1:0]   step_q;
  logic [AMP_W-1:0]    level_q;
  logic [QUOT_W-1:0]   k_q;
  logic                out_valid_q;
  logic                out_valid_d;
  logic [AMP_W-1:0]    amp_q;

  logic                accept;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;
  logic [PERIOD_W-1:0] div_rem;
  logic                out_free;
  logic                load_out;
  logic                advance;
  logic [STEP_W-1:0]   step_nxt;
  logic [AMP_W-1:0]    level_d;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign div_start   = (state_q == ST_START) && (accum_q != '0) && (period_q != '0);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == ST_FIN) && out_free;
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign advance     = (k_q != '0) && (lin_cnt_q != '0) && (len_cnt_q != '0);
  assign step_nxt    = step_q + k_q[STEP_W-1:0];
  assign level_d     = advance ? wave_level(step_nxt - STEP_W'(1)) : level_q;

  trich_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (accum_q - ACCUM_W'(1)),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ns_q        <= NS_RESET;
      ctrl_q      <= 1'b0;
      lin_load_q  <= '0;
      period_q    <= '0;
      len_en_q    <= 1'b0;
      len_cnt_q   <= '0;
      reload_q    <= 1'b0;
      lin_cnt_q   <= '0;
      accum_q     <= '0;
      step_q      <= '0;
      level_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ns_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_WRITE: begin
                case (reg_index_i)
                  REG_CONTROL: begin
                    ctrl_q     <= write_data_i[7];
                    lin_load_q <= write_data_i[LIN_W-1:0];
                  end
                  REG_PER_LO: begin
                    period_q[7:0] <= write_data_i;
                  end
                  REG_PER_HI: begin
                    period_q[PERIOD_W-1:8] <= write_data_i[PERIOD_W-9:0];
                    if (len_en_q) begin
                      len_cnt_q <= LEN_TAB[write_data_i[7:3]];
                    end
                    reload_q <= 1'b1;
                  end
                  default: begin
                    len_en_q <= write_data_i[0];
                  end
                endcase
              end
              REQ_LINEAR: begin
                if (reload_q) begin
                  lin_cnt_q <= lin_load_q;
                end else if (lin_cnt_q != '0) begin
                  lin_cnt_q <= lin_cnt_q - 1'b1;
                end
                // A pending reload is consumed here, and the flag is cleared whether or not the
                // control flag is set, so the flag always ends clear.
                reload_q <= 1'b0;
              end
              REQ_LENGTH: begin
                if (!ctrl_q && (len_cnt_q != '0)) begin
                  len_cnt_q <= len_cnt_q - 1'b1;
                end
              end
              default: begin
                accum_q <= accum_q + ACCUM_W'(ns_q[NS_W-1:ADV_SHIFT]);
                state_q <= ST_START;
              end
            endcase
          end
        end
        ST_START: begin
          k_q <= '0;
          if (div_start) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            k_q     <= div_quot;
            accum_q <= ACCUM_W'(div_rem) + ACCUM_W'(1);
            state_q <= ST_FIN;
          end
        end
        default: begin
          if (out_free) begin
            if (advance) begin
              step_q <= step_nxt;
            end
            level_q <= level_d;
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      amp_q <= level_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign amplitude_o = amp_q;

endmodule

`default_nettype wire

>>> hw/rtl/trich_checker.sv
// Port-level checker for the triangle channel and its bind to the top level.
`default_nettype none

module trich_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [trich_pkg::REQ_W-1:0]  req_type_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [trich_pkg::AMP_W-1:0]  amplitude_o
);
  import trich_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // A sample request occupies the channel for its whole computation.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (req_type_i == REQ_SAMPLE) |=> in_stall_o)
    else $error("input not stalled after sample request transfer");

  // Writes and ticks finish in the cycle of their transfer and do not stall the input.
  a_other_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (req_type_i != REQ_SAMPLE) |=> !in_stall_o)
    else $error("input stalled after a non-sample transfer");

  // A new amplitude appears only at the end of a sample computation.
  a_out_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("amplitude presented without a sample computation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(amplitude_o))
    else $error("amplitude changed while stalled");

endmodule

bind triangle_wave_channel trich_checker u_trich_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .amplitude_o (amplitude_o)
);

`default_nettype wire
